@@ sv/verg_pkg.sv @@
// Package for the vsync excess-rate guard: widths, timing constants and
// the item and result types shared by the interfaces and modules.
// No dependencies.
package verg_pkg;

  localparam int unsigned TsWidth      = 64;
  localparam int unsigned CountWidth   = 32;
  localparam int unsigned RefreshWidth = 10;
  localparam int unsigned RateWidth    = RefreshWidth + 1;
  localparam int unsigned NsWidth      = 30;
  localparam int unsigned LhsWidth     = CountWidth + NsWidth;
  localparam int unsigned ProdWidth    = TsWidth + RateWidth;
  localparam int unsigned StreakWidth  = 2;

  localparam logic [NsWidth-1:0]     NsPerSecond   = NsWidth'(1_000_000_000);
  localparam logic [TsWidth-1:0]     WindowNs      = TsWidth'(100_000_000);
  localparam logic [RateWidth-1:0]   MinRateHz     = RateWidth'(240);
  localparam logic [StreakWidth-1:0] NeededWindows = StreakWidth'(2);
  localparam logic [StreakWidth-1:0] StreakMax     = '1;
  localparam logic [CountWidth-1:0]  CountMax      = '1;

  typedef struct packed {
    logic [TsWidth-1:0] timestamp_ns;
    logic               pace_expected;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  typedef struct packed {
    logic fallback_triggered;
    logic fallback_active;
    logic window_excessive;
  } result_t;

endpackage

@@ sv/verg_if.sv @@
// Valid/ready channel interfaces for the guard: present events in, guard
// results out, and the refresh-rate register write. Depends on verg_pkg.
interface verg_in_if;
  logic                         valid;
  logic                         ready;
  logic [verg_pkg::TsWidth-1:0] timestamp_ns;
  logic                         pace_expected;

  modport source (output valid, output timestamp_ns, output pace_expected, input ready);
  modport sink   (input valid, input timestamp_ns, input pace_expected, output ready);
endinterface

interface verg_out_if;
  logic valid;
  logic ready;
  logic fallback_triggered;
  logic fallback_active;
  logic window_excessive;

  modport source (output valid, output fallback_triggered, output fallback_active,
                  output window_excessive, input ready);
  modport sink   (input valid, input fallback_triggered, input fallback_active,
                  input window_excessive, output ready);
endinterface

interface verg_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [verg_pkg::RefreshWidth-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/verg_in_reg.sv @@
// Input register stage of the guard: captures one event beat and holds it
// until the core takes it. Depends on verg_pkg and verg_in_if.
module verg_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  verg_in_if.sink          in_i,
  input  logic             advance_i,
  output verg_pkg::stage_t stage_o
);
  import verg_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  // take a new beat when empty or when the held one moves on this cycle
  assign in_i.ready = !valid_q || advance_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.timestamp_ns  <= in_i.timestamp_ns;
      item_q.pace_expected <= in_i.pace_expected;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

@@ sv/verg_core.sv @@
// Guard core: window state, refresh register, the rate compare and the
// result register. Depends on verg_pkg, verg_out_if and verg_cfg_if.
module verg_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  verg_pkg::stage_t stage_i,
  output logic             advance_o,
  verg_cfg_if.sink         cfg_i,
  verg_out_if.source       out_o
);
  import verg_pkg::*;

  logic [RefreshWidth-1:0] refresh_q;
  logic                    started_q, started_d;
  logic [TsWidth-1:0]      start_q, start_d;
  logic [CountWidth-1:0]   count_q, count_d;
  logic [StreakWidth-1:0]  streak_q, streak_d;
  logic                    latched_q, latched_d;

  logic    out_valid_q;
  result_t res_q, res_d;

  logic [CountWidth-1:0] count_inc;
  logic [TsWidth-1:0]    elapsed;
  logic [RateWidth-1:0]  rate_x2;
  logic [RateWidth-1:0]  rate;
  logic [LhsWidth-1:0]   lhs;
  logic [ProdWidth-1:0]  prod;
  logic                  excessive;
  logic [StreakWidth-1:0] streak_up;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refresh_q <= '0;
    end else if (cfg_i.valid) begin
      refresh_q <= cfg_i.data;
    end
  end

  // result register empties or is taken this cycle
  assign advance_o = stage_i.valid && (!out_valid_q || out_o.ready);

  // twice nominal refresh, floored at the minimum (unknown refresh lands there too)
  assign rate_x2   = {refresh_q, 1'b0};
  assign rate      = (rate_x2 < MinRateHz) ? MinRateHz : rate_x2;
  assign count_inc = (count_q == CountMax) ? count_q : count_q + CountWidth'(1);
  assign elapsed   = stage_i.item.timestamp_ns - start_q;
  assign lhs       = {{NsWidth{1'b0}}, count_inc} * {{CountWidth{1'b0}}, NsPerSecond};
  assign prod      = {{RateWidth{1'b0}}, elapsed} * {{TsWidth{1'b0}}, rate};
  assign excessive = {{(ProdWidth-LhsWidth){1'b0}}, lhs} > prod;
  assign streak_up = (streak_q == StreakMax) ? streak_q : streak_q + StreakWidth'(1);

  always_comb begin
    started_d = started_q;
    start_d   = start_q;
    count_d   = count_q;
    streak_d  = streak_q;
    latched_d = latched_q;
    res_d     = '0;
    if (!stage_i.item.pace_expected) begin
      started_d = 1'b0;
      start_d   = '0;
      count_d   = '0;
      streak_d  = '0;
      latched_d = 1'b0;
    end else if (latched_q) begin
      res_d.fallback_active = 1'b1;
    end else if (!started_q || (stage_i.item.timestamp_ns <= start_q)) begin
      // fresh window at this timestamp
      started_d = 1'b1;
      start_d   = stage_i.item.timestamp_ns;
      count_d   = '0;
      streak_d  = '0;
    end else if (elapsed >= WindowNs) begin
      streak_d               = excessive ? streak_up : '0;
      start_d                = stage_i.item.timestamp_ns;
      count_d                = '0;
      res_d.window_excessive = excessive;
      if (streak_d >= NeededWindows) begin
        latched_d                = 1'b1;
        res_d.fallback_triggered = 1'b1;
        res_d.fallback_active    = 1'b1;
      end
    end else begin
      count_d = count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      start_q     <= '0;
      count_q     <= '0;
      streak_q    <= '0;
      latched_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance_o) begin
        started_q <= started_d;
        start_q   <= start_d;
        count_q   <= count_d;
        streak_q  <= streak_d;
        latched_q <= latched_d;
      end
      if (advance_o) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.fallback_triggered = res_q.fallback_triggered;
  assign out_o.fallback_active    = res_q.fallback_active;
  assign out_o.window_excessive   = res_q.window_excessive;

  a_trig_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && res_d.fallback_triggered |=> latched_q)
    else $error("fallback trigger did not latch");

  a_latch_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && latched_q && stage_i.item.pace_expected |=> latched_q)
    else $error("latched fallback dropped while vsync expected");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && !stage_i.item.pace_expected |=> !started_q && !latched_q
      && (count_q == '0) && (streak_q == '0))
    else $error("guard not cleared");

  a_trig_excessive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.fallback_triggered |-> res_q.window_excessive
      && res_q.fallback_active)
    else $error("trigger without excessive window");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_o |=> $stable(latched_q) && $stable(start_q) && $stable(count_q))
    else $error("guard state moved without a beat");

endmodule

@@ sv/vsync_excess_rate_guard.sv @@
// Top level of the vsync excess-rate guard: input register stage and core.
// Depends on verg_pkg, verg_if, verg_in_reg and verg_core.
//
// Takes one present-completion beat per clock and returns one result beat
// per event, passing through the input register and then the result
// register; the whole state update for an event is one pass of logic
// between those two registers, so back-to-back events sustain one per
// cycle while the output side keeps taking. The refresh register write
// channel is always ready; write it only while no event is in flight.
module vsync_excess_rate_guard (
  input  logic        clk_i,
  input  logic        rst_ni,
  verg_in_if.sink     in_i,
  verg_cfg_if.sink    cfg_i,
  verg_out_if.source  out_o
);
  import verg_pkg::*;

  stage_t stage;
  logic   advance;

  verg_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  verg_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (stage),
    .advance_o (advance),
    .cfg_i     (cfg_i),
    .out_o     (out_o)
  );

endmodule
